FILE: sv/dtfp_pkg.sv
// dtfp_pkg: shared types, codes and constants for the decimal text to fixed-point block
// no dependencies; used by dtfp_out_if and imported by every module
`timescale 1ns / 1ps
`default_nettype none

package dtfp_pkg;

  localparam int unsigned FractionDigitsDef = 4;

  localparam logic [7:0]  CharMinus = 8'h2D;
  localparam logic [7:0]  CharDot   = 8'h2E;
  localparam logic [7:0]  CharZero  = 8'h30;
  localparam logic [7:0]  CharNine  = 8'h39;
  localparam logic [63:0] Int64Top  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_NO_DIGITS   = 3'd2,
    ST_TOO_LARGE   = 3'd3,
    ST_GARBAGE     = 3'd4,
    ST_FRAC_DIGITS = 3'd5,
    ST_NEGATIVE    = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    PH_SIGN  = 4'b0001,
    PH_WHOLE = 4'b0010,
    PH_FRAC  = 4'b0100,
    PH_STOP  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic any_char;
    logic minus;
    logic whole_digit;
    logic frac_digit;
    logic frac_excess;
    logic stopped;
    logic early_ovf;
  } acc_flags_t;

  function automatic logic [63:0] pow10_tab(input logic [3:0] n);
    logic [63:0] p;
    case (n)
      4'd0:    p = 64'd1;
      4'd1:    p = 64'd10;
      4'd2:    p = 64'd100;
      4'd3:    p = 64'd1000;
      4'd4:    p = 64'd10000;
      4'd5:    p = 64'd100000;
      4'd6:    p = 64'd1000000;
      4'd7:    p = 64'd10000000;
      4'd8:    p = 64'd100000000;
      4'd9:    p = 64'd1000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: sv/dtfp_if.sv
// dtfp_if: valid/ready channel interfaces for characters in and results out
// depends on dtfp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dtfp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;

  modport source (output valid, output kind, output char_code, input ready);
  modport sink   (input valid, input kind, input char_code, output ready);
endinterface

interface dtfp_out_if;
  logic                 valid;
  logic                 ready;
  dtfp_pkg::status_e    status;
  logic [62:0]          scaled_value;

  modport source (output valid, output status, output scaled_value, input ready);
  modport sink   (input valid, input status, input scaled_value, output ready);
endinterface

`default_nettype wire

FILE: sv/dtfp_accum.sv
// dtfp_accum: per-character parse state, whole and fraction accumulators
// depends on dtfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtfp_accum #(
  parameter int unsigned FRACTION_DIGITS = dtfp_pkg::FractionDigitsDef,
  parameter int unsigned WHOLE_W         = 54,
  parameter int unsigned FRAC_W          = 14
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fire_i,
  input  wire logic                  kind_i,
  input  wire logic [7:0]            char_code_i,
  output dtfp_pkg::acc_flags_t       flags_o,
  output logic [WHOLE_W-1:0]         whole_o,
  output logic [62:0]                scaled_o,
  output logic [FRAC_W-1:0]          frac_o
);
  import dtfp_pkg::*;

  localparam logic [63:0] Scale    = pow10_tab(4'(FRACTION_DIGITS));
  localparam logic [63:0] MaxWhole = Int64Top / Scale;
  localparam int unsigned CntW     = $clog2(FRACTION_DIGITS + 2);

  phase_e               phase_q, phase_d;
  logic                 any_q, any_d;
  logic                 minus_q, minus_d;
  logic                 wds_q, wds_d;
  logic                 ovf_q, ovf_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [WHOLE_W-1:0]   whole_q, whole_d;
  logic [62:0]          scaled_q, scaled_d;
  logic [FRAC_W-1:0]    frac_q, frac_d;

  logic                 is_digit;
  logic [3:0]           digit;
  logic [3:0]           pad_idx;
  logic [FRAC_W-1:0]    pad;
  logic                 take_whole;
  logic                 take_frac;

  assign is_digit = (char_code_i >= CharZero) && (char_code_i <= CharNine);
  assign digit    = 4'(char_code_i - CharZero);
  assign pad_idx  = 4'(FRACTION_DIGITS - 1) - 4'(cnt_q);
  assign pad      = FRAC_W'(pow10_tab(pad_idx));

  always_comb begin
    phase_d    = phase_q;
    any_d      = any_q;
    minus_d    = minus_q;
    wds_d      = wds_q;
    ovf_d      = ovf_q;
    cnt_d      = cnt_q;
    whole_d    = whole_q;
    scaled_d   = scaled_q;
    frac_d     = frac_q;
    take_whole = 1'b0;
    take_frac  = 1'b0;
    if (fire_i) begin
      if (kind_i) begin
        phase_d  = PH_SIGN;
        any_d    = 1'b0;
        minus_d  = 1'b0;
        wds_d    = 1'b0;
        ovf_d    = 1'b0;
        cnt_d    = '0;
        whole_d  = '0;
        scaled_d = '0;
        frac_d   = '0;
      end else begin
        any_d = 1'b1;
        if (!ovf_q) begin
          case (phase_q)
            PH_SIGN: begin
              phase_d = PH_WHOLE;
              if (char_code_i == CharMinus) begin
                minus_d = 1'b1;
              end else begin
                take_whole = 1'b1;
              end
            end
            PH_WHOLE: take_whole = 1'b1;
            PH_FRAC:  take_frac  = 1'b1;
            PH_STOP:  ;
            default:  ;
          endcase
        end
        if (take_whole) begin
          if (is_digit) begin
            if (64'(whole_q) > MaxWhole) begin
              ovf_d = 1'b1;
            end else begin
              whole_d  = WHOLE_W'((whole_q << 3) + (whole_q << 1) + WHOLE_W'(digit));
              scaled_d = 63'((scaled_q << 3) + (scaled_q << 1) + 63'(digit) * 63'(Scale));
              wds_d    = 1'b1;
            end
          end else if (char_code_i == CharDot) begin
            phase_d = PH_FRAC;
          end else begin
            phase_d = PH_STOP;
          end
        end
        if (take_frac) begin
          if (is_digit) begin
            if (cnt_q < CntW'(FRACTION_DIGITS)) begin
              frac_d = FRAC_W'(frac_q + FRAC_W'(digit) * pad);
            end
            if (cnt_q <= CntW'(FRACTION_DIGITS)) begin
              cnt_d = cnt_q + CntW'(1);
            end
          end else begin
            phase_d = PH_STOP;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SIGN;
      any_q    <= 1'b0;
      minus_q  <= 1'b0;
      wds_q    <= 1'b0;
      ovf_q    <= 1'b0;
      cnt_q    <= '0;
      whole_q  <= '0;
      scaled_q <= '0;
      frac_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      any_q    <= any_d;
      minus_q  <= minus_d;
      wds_q    <= wds_d;
      ovf_q    <= ovf_d;
      cnt_q    <= cnt_d;
      whole_q  <= whole_d;
      scaled_q <= scaled_d;
      frac_q   <= frac_d;
    end
  end

  always_comb begin
    flags_o.any_char    = any_q;
    flags_o.minus       = minus_q;
    flags_o.whole_digit = wds_q;
    flags_o.frac_digit  = (cnt_q != '0);
    flags_o.frac_excess = (cnt_q > CntW'(FRACTION_DIGITS));
    flags_o.stopped     = (phase_q == PH_STOP);
    flags_o.early_ovf   = ovf_q;
  end

  assign whole_o  = whole_q;
  assign scaled_o = scaled_q;
  assign frac_o   = frac_q;

endmodule

`default_nettype wire

FILE: sv/dtfp_result.sv
// dtfp_result: end-of-text checks, final range check and the output register
// depends on dtfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtfp_result #(
  parameter int unsigned FRACTION_DIGITS = dtfp_pkg::FractionDigitsDef,
  parameter int unsigned WHOLE_W         = 54,
  parameter int unsigned FRAC_W          = 14
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  end_fire_i,
  input  wire dtfp_pkg::acc_flags_t  flags_i,
  input  wire logic [WHOLE_W-1:0]    whole_i,
  input  wire logic [62:0]           scaled_i,
  input  wire logic [FRAC_W-1:0]     frac_i,
  input  wire logic                  out_rdy_i,
  output logic                       out_vld_o,
  output dtfp_pkg::status_e          status_o,
  output logic [62:0]                value_o,
  output logic                       in_rdy_o
);
  import dtfp_pkg::*;

  localparam logic [63:0] Scale    = pow10_tab(4'(FRACTION_DIGITS));
  localparam logic [63:0] MaxWhole = Int64Top / Scale;
  localparam logic [63:0] MaxFrac  = Int64Top % Scale;

  logic         vld_q, vld_d;
  status_e      status_q, status_d;
  logic [62:0]  value_q, value_d;
  logic         too_big;

  assign too_big = (64'(whole_i) > MaxWhole) ||
                   ((64'(whole_i) == MaxWhole) && (64'(frac_i) > MaxFrac));

  always_comb begin
    value_d = '0;
    if (flags_i.early_ovf) begin
      status_d = ST_TOO_LARGE;
    end else if (!flags_i.any_char) begin
      status_d = ST_EMPTY;
    end else if (!flags_i.whole_digit && !flags_i.frac_digit) begin
      status_d = ST_NO_DIGITS;
    end else if (flags_i.stopped) begin
      status_d = ST_GARBAGE;
    end else if (flags_i.frac_excess) begin
      status_d = ST_FRAC_DIGITS;
    end else if (flags_i.minus) begin
      status_d = ST_NEGATIVE;
    end else if (too_big) begin
      status_d = ST_TOO_LARGE;
    end else begin
      status_d = ST_OK;
      value_d  = scaled_i + 63'(frac_i);
    end
  end

  assign in_rdy_o = !vld_q || out_rdy_i;

  always_comb begin
    vld_d = vld_q;
    if (out_rdy_i) begin
      vld_d = 1'b0;
    end
    if (end_fire_i) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_fire_i) begin
      status_q <= status_d;
      value_q  <= value_d;
    end
  end

  assign out_vld_o = vld_q;
  assign status_o  = status_q;
  assign value_o   = value_q;

endmodule

`default_nettype wire

FILE: sv/decimal_text_to_fixed_point.sv
// decimal_text_to_fixed_point: top level, parses decimal price text into a scaled integer
// depends on dtfp_pkg, dtfp_if, dtfp_accum, dtfp_result
`timescale 1ns / 1ps
`default_nettype none

// One character transaction is taken per cycle on char_i (kind 0) while char_i is
// ready; an end-of-text transaction (kind 1) produces one result transaction on
// result_o in the next cycle, with a status code and the price times 10^FRACTION_DIGITS
// (zero unless status is ok), and returns the parser to its empty state. The
// character step is a multiply by ten and an add on the accumulators, and the final
// checks sit between the accumulators and the result register. char_i stays ready
// while a held result is being taken; it stalls only while result_o is full and
// not ready. There is no configuration and no start-up delay after reset.

module decimal_text_to_fixed_point #(
  parameter int unsigned FRACTION_DIGITS = dtfp_pkg::FractionDigitsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  dtfp_in_if.sink       char_i,
  dtfp_out_if.source    result_o
);
  import dtfp_pkg::*;

  localparam logic [63:0] Scale    = pow10_tab(4'(FRACTION_DIGITS));
  localparam logic [63:0] MaxWhole = Int64Top / Scale;
  localparam int unsigned WholeW   = $clog2(MaxWhole + 64'd1) + 4;
  localparam int unsigned FracW    = $clog2(Scale);

  logic               in_rdy;
  logic               fire;
  logic               end_fire;
  acc_flags_t         flags;
  logic [WholeW-1:0]  whole;
  logic [62:0]        scaled;
  logic [FracW-1:0]   frac;

  assign char_i.ready = in_rdy;
  assign fire         = char_i.valid && in_rdy;
  assign end_fire     = fire && char_i.kind;

  dtfp_accum #(
    .FRACTION_DIGITS (FRACTION_DIGITS),
    .WHOLE_W         (WholeW),
    .FRAC_W          (FracW)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .kind_i      (char_i.kind),
    .char_code_i (char_i.char_code),
    .flags_o     (flags),
    .whole_o     (whole),
    .scaled_o    (scaled),
    .frac_o      (frac)
  );

  dtfp_result #(
    .FRACTION_DIGITS (FRACTION_DIGITS),
    .WHOLE_W         (WholeW),
    .FRAC_W          (FracW)
  ) u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .end_fire_i (end_fire),
    .flags_i    (flags),
    .whole_i    (whole),
    .scaled_i   (scaled),
    .frac_i     (frac),
    .out_rdy_i  (result_o.ready),
    .out_vld_o  (result_o.valid),
    .status_o   (result_o.status),
    .value_o    (result_o.scaled_value),
    .in_rdy_o   (in_rdy)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// tb: self-checking testbench for decimal_text_to_fixed_point
// depends on dtfp_pkg, dtfp_if and the block itself; feeds price texts and checks every result
`timescale 1ns / 1ps

module tb;
  import dtfp_pkg::*;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;
  localparam int unsigned FRAC_DIGITS = FractionDigitsDef;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TARGET_ITEMS = 550;

  function automatic logic [63:0] ten_to(int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  localparam logic [63:0] PRICE_SCALE = ten_to(FRAC_DIGITS);
  localparam logic [63:0] MAX_WHOLE   = Int64Top / PRICE_SCALE;
  localparam logic [63:0] MAX_FRAC    = Int64Top % PRICE_SCALE;

  typedef struct packed {
    logic       drain;
    logic       kind;
    logic [7:0] code;
  } char_txn_t;

  typedef struct packed {
    status_e     status;
    logic [62:0] value;
  } price_t;

  logic clk_i;
  logic rst_ni;

  dtfp_in_if  char_bus ();
  dtfp_out_if result_bus ();

  decimal_text_to_fixed_point DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_bus),
    .result_o (result_bus)
  );

  char_txn_t pending_txns[$];
  price_t    expected_prices[$];

  // price parser state
  phase_e      txt_phase;
  logic        txt_any;
  logic        txt_minus;
  logic [63:0] txt_whole;
  logic        txt_whole_seen;
  logic [63:0] txt_frac;
  int unsigned txt_frac_cnt;
  logic        txt_ovf;

  int  error_count;
  int  cycle_count;
  int  n_queued;
  int  n_chars;
  int  n_texts;
  int  n_checked;
  int  status_hits[7];
  int  send_gap;
  int  ready_hold;
  logic calm;
  logic char_taken;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    error_count++;
  endtask

  function automatic void clear_text();
    txt_phase      = PH_SIGN;
    txt_any        = 1'b0;
    txt_minus      = 1'b0;
    txt_whole      = '0;
    txt_whole_seen = 1'b0;
    txt_frac       = '0;
    txt_frac_cnt   = 0;
    txt_ovf        = 1'b0;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    logic is_num;
    is_num = (c >= CharZero) && (c <= CharNine);
    txt_any = 1'b1;
    if (txt_ovf || txt_phase == PH_STOP) return;
    if (txt_phase == PH_SIGN) begin
      txt_phase = PH_WHOLE;
      if (c == CharMinus) begin
        txt_minus = 1'b1;
        return;
      end
    end
    if (txt_phase == PH_WHOLE) begin
      if (is_num) begin
        if (txt_whole > MAX_WHOLE) begin
          txt_ovf = 1'b1;
        end else begin
          txt_whole      = txt_whole * 64'd10 + 64'(c - CharZero);
          txt_whole_seen = 1'b1;
        end
      end else if (c == CharDot) begin
        txt_phase = PH_FRAC;
      end else begin
        txt_phase = PH_STOP;
      end
      return;
    end
    if (is_num) begin
      if (txt_frac_cnt < FRAC_DIGITS) txt_frac = txt_frac * 64'd10 + 64'(c - CharZero);
      if (txt_frac_cnt <= FRAC_DIGITS) txt_frac_cnt++;
    end else begin
      txt_phase = PH_STOP;
    end
  endfunction

  function automatic price_t close_price();
    price_t      p;
    logic [63:0] frac;
    p.status = ST_OK;
    p.value  = '0;
    frac     = txt_frac;
    if (txt_ovf) begin
      p.status = ST_TOO_LARGE;
    end else if (!txt_any) begin
      p.status = ST_EMPTY;
    end else if (!txt_whole_seen && txt_frac_cnt == 0) begin
      p.status = ST_NO_DIGITS;
    end else if (txt_phase == PH_STOP) begin
      p.status = ST_GARBAGE;
    end else if (txt_frac_cnt > FRAC_DIGITS) begin
      p.status = ST_FRAC_DIGITS;
    end else if (txt_minus) begin
      p.status = ST_NEGATIVE;
    end else begin
      for (int unsigned i = txt_frac_cnt; i < FRAC_DIGITS; i++) frac = frac * 64'd10;
      if (txt_whole > MAX_WHOLE || (txt_whole == MAX_WHOLE && frac > MAX_FRAC)) begin
        p.status = ST_TOO_LARGE;
      end else begin
        p.value = 63'(txt_whole * PRICE_SCALE + frac);
      end
    end
    clear_text();
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CharZero + $urandom_range(0, 9));
  endfunction

  task automatic queue_char(input logic [7:0] c);
    pending_txns.push_back('{drain: 1'b0, kind: KIND_CHAR, code: c});
    n_queued++;
  endtask

  task automatic queue_end();
    pending_txns.push_back('{drain: 1'b0, kind: KIND_END, code: 8'($urandom_range(0, 255))});
    n_queued++;
  endtask

  task automatic queue_drain();
    pending_txns.push_back('{drain: 1'b1, kind: KIND_END, code: 8'h00});
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
    queue_end();
  endtask

  task automatic queue_random_text();
    logic [7:0] t[$];
    int shape;
    int r;
    int n;
    int v;
    int pos;
    logic [7:0] g;
    string top;
    shape = $urandom_range(0, 99);
    if (shape < 5) begin
      // empty text
    end else if (shape < 12) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        r = $urandom_range(0, 3);
        if (r == 0)      t.push_back(CharMinus);
        else if (r == 1) t.push_back(CharDot);
        else if (r == 2) t.push_back(rand_digit());
        else             t.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      if ($urandom_range(0, 4) == 0) t.push_back(CharMinus);
      r = $urandom_range(0, 9);
      if (r == 0) begin
        // around the largest representable price
        top = ($urandom_range(0, 1) == 0) ? "922337203685477" : "922337203685478";
        for (int i = 0; i < top.len(); i++) t.push_back(top[i]);
        t.push_back(CharDot);
        v = $urandom_range(5800, 5815);
        for (int k = 1000; k >= 1; k = k / 10) t.push_back(8'(CharZero + (v / k) % 10));
      end else begin
        n = (r == 1) ? $urandom_range(15, 18) : $urandom_range(0, 6);
        for (int i = 0; i < n; i++) t.push_back((i == 0 && r == 1) ? 8'h39 : rand_digit());
        if ($urandom_range(0, 2) != 0) begin
          t.push_back(CharDot);
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
          repeat (n) t.push_back(rand_digit());
        end
      end
      if (shape < 30) begin
        r = $urandom_range(0, 3);
        if (r == 0)      g = CharMinus;
        else if (r == 1) g = CharDot;
        else             g = 8'($urandom_range(0, 255));
        pos = $urandom_range(0, t.size());
        if (pos >= t.size()) t.push_back(g);
        else                 t.insert(pos, g);
      end
    end
    foreach (t[i]) queue_char(t[i]);
    queue_end();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni                  = 1'b0;
    char_bus.valid          = 1'b0;
    char_bus.kind           = KIND_CHAR;
    char_bus.char_code      = 8'h00;
    result_bus.ready        = 1'b0;
    error_count             = 0;
    cycle_count             = 0;
    n_queued                = 0;
    n_chars                 = 0;
    n_texts                 = 0;
    n_checked               = 0;
    send_gap                = 0;
    ready_hold              = 0;
    calm                    = 1'b0;
    char_taken              = 1'b0;
    foreach (status_hits[i]) status_hits[i] = 0;
    clear_text();

    // directed texts
    queue_text("");
    queue_text("-.");
    queue_text("-7");
    queue_char(8'hFF);
    queue_end();
    queue_char(8'h33);
    queue_char(8'h00);
    queue_end();
    queue_text(".5");
    queue_text("0.12345");
    queue_text("922337203685477.5808");
    queue_text("99999999999999999");
    queue_drain();

    while (n_queued < TARGET_ITEMS) begin
      queue_random_text();
      if ($urandom_range(0, 19) == 0) queue_drain();
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_txns.size() != 0 || char_bus.valid || expected_prices.size() != 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("run covered %0d texts made of %0d characters; %0d results checked",
             n_texts, n_chars, n_checked);
    $display("status mix: ok %0d, empty %0d, no digits %0d, too large %0d, garbage %0d, %s %0d, %s %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4],
             "excess fraction", status_hits[5], "negative", status_hits[6]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  always @(negedge clk_i) begin : drive_chars
    char_txn_t txn;
    logic      next_valid;
    next_valid = char_bus.valid;
    if (rst_ni && (!char_bus.valid || char_taken)) begin
      next_valid = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
      end else if (pending_txns.size() != 0) begin
        if (pending_txns[0].drain) begin
          if (expected_prices.size() == 0) void'(pending_txns.pop_front());
        end else begin
          txn                 = pending_txns.pop_front();
          next_valid          = 1'b1;
          char_bus.kind      <= txn.kind;
          char_bus.char_code <= txn.code;
          send_gap            = pick_gap();
        end
      end
    end
    char_bus.valid <= next_valid;
  end

  always @(negedge clk_i) begin : drive_ready
    if (ready_hold != 0) begin
      ready_hold--;
      result_bus.ready <= 1'b0;
    end else begin
      ready_hold = pick_gap();
      result_bus.ready <= (ready_hold == 0);
    end
  end

  always @(posedge clk_i) begin : check_results
    price_t want;
    if (rst_ni) begin
      char_taken <= char_bus.valid && char_bus.ready;
      if (char_bus.valid && char_bus.ready) begin
        if (char_bus.kind == KIND_END) begin
          expected_prices.push_back(close_price());
          n_texts++;
        end else begin
          take_char(char_bus.char_code);
          n_chars++;
        end
      end
      if (result_bus.valid && result_bus.ready) begin
        if (expected_prices.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d value %0d",
                                    result_bus.status, result_bus.scaled_value));
        end else begin
          want = expected_prices.pop_front();
          n_checked++;
          status_hits[want.status]++;
          if (result_bus.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result_bus.status, want.status));
          if (result_bus.scaled_value !== want.value)
            report_mismatch($sformatf("scaled value %0d, expected %0d",
                                      result_bus.scaled_value, want.value));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count % 200 == 0) calm = ($urandom_range(0, 2) == 0);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_prices.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
